// ----- rtl/dorq_pkg.sv -----
`default_nettype none

package dorq_pkg;

    localparam int unsigned DEADLINE_W = 32;
    localparam int unsigned MAX_OUT    = 16;
    localparam int unsigned NDISP_W    = 5;

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_SHUTDOWN = 2'd2;

    localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
    localparam logic [2:0] KIND_REJECTED   = 3'd1;
    localparam logic [2:0] KIND_DISPATCHED = 3'd2;
    localparam logic [2:0] KIND_NOTHING    = 3'd3;
    localparam logic [2:0] KIND_SHUTDOWN   = 3'd4;

    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_TICK = 2'b10
    } t_state;

    // a strictly before b, by wrapped difference
    function automatic logic deadline_before(input logic [DEADLINE_W-1:0] a,
                                             input logic [DEADLINE_W-1:0] b);
        logic [DEADLINE_W-1:0] diff;
        diff = a - b;
        return diff[DEADLINE_W-1];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dorq_cell.sv -----
`default_nettype none

// One slot of the sorted chain. Insert: take left neighbor if the new entry
// lands left of us, else take the new entry if it lands here. Pop: take right. Clear: empty.
module dorq_cell import dorq_pkg::*; #(
    parameter int unsigned PAYLOAD_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cell_cmd                i_cmd,
    input  wire logic [DEADLINE_W-1:0]    i_new_dl,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_new_pay,
    input  wire logic                     i_left_cond,
    input  wire logic                     i_left_valid,
    input  wire logic [DEADLINE_W-1:0]    i_left_dl,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_left_pay,
    input  wire logic                     i_right_valid,
    input  wire logic [DEADLINE_W-1:0]    i_right_dl,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_right_pay,
    output logic                          o_cond,
    output logic                          o_valid,
    output logic [DEADLINE_W-1:0]         o_dl,
    output logic [PAYLOAD_WIDTH-1:0]      o_pay
);

    logic                     r_valid, n_valid;
    logic [DEADLINE_W-1:0]    r_dl, n_dl;
    logic [PAYLOAD_WIDTH-1:0] r_pay, n_pay;
    logic                     w_cond;

    // new entry goes at or left of this slot
    assign w_cond = !r_valid || deadline_before(i_new_dl, r_dl);

    always_comb begin
        n_valid = r_valid;
        n_dl    = r_dl;
        n_pay   = r_pay;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.insert) begin
            if (i_left_cond) begin
                n_valid = i_left_valid;
                n_dl    = i_left_dl;
                n_pay   = i_left_pay;
            end else if (w_cond) begin
                n_valid = 1'b1;
                n_dl    = i_new_dl;
                n_pay   = i_new_pay;
            end
        end else if (i_cmd.pop) begin
            n_valid = i_right_valid;
            n_dl    = i_right_dl;
            n_pay   = i_right_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl  <= n_dl;
        r_pay <= n_pay;
    end

    assign o_cond  = w_cond;
    assign o_valid = r_valid;
    assign o_dl    = r_dl;
    assign o_pay   = r_pay;

endmodule

`default_nettype wire

// ----- rtl/deadline_ordered_retry_queue_top.sv -----
// Schedule, shutdown: result registered at the input transfer, shown in the next cycle.
// Tick: advance time, then one result per cycle while the receiver takes them; the tick
// holds the input until its last result. Schedule, shutdown: one per cycle as results drain.
// Pops go through the single head-of-chain dispatch port, one per cycle as results drain.
// Reset (i_rst_n low, synchronous): queue empty, time, reject count and shutdown flag cleared.
`default_nettype none

module deadline_ordered_retry_queue_top import dorq_pkg::*; #(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned PAYLOAD_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_payload,
    input  wire logic [15:0] i_delay_ticks,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_dispatched_payload,
    output logic [4:0]       o_pending_count,
    output logic [31:0]      o_reject_count,
    output logic             o_last
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // Chain taps; entry CAPACITY is an always-empty sentinel feeding the last cell on pop.
    logic                     w_valid [CAPACITY+1];
    logic [DEADLINE_W-1:0]    w_dl    [CAPACITY+1];
    logic [PAYLOAD_WIDTH-1:0] w_pay   [CAPACITY+1];
    logic                     w_cond  [CAPACITY];

    t_state                r_state, n_state;
    logic [DEADLINE_W-1:0] r_time, n_time;
    logic [31:0]           r_rej, n_rej;
    logic                  r_stopped, n_stopped;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [NDISP_W-1:0]    r_ndisp, n_ndisp;

    logic        r_ovalid, n_ovalid;
    logic [2:0]  r_okind, n_okind;
    logic [31:0] r_opay, n_opay;
    logic        r_olast, n_olast;

    t_cell_cmd             w_cmd;
    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_head_due;
    logic                  w_next_due;
    logic                  w_budget;
    logic [DEADLINE_W-1:0] w_new_dl;

    assign w_valid[CAPACITY] = 1'b0;
    assign w_dl[CAPACITY]    = '0;
    assign w_pay[CAPACITY]   = '0;

    // Output register frees when empty or being drained this cycle.
    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_new_dl   = r_time + DEADLINE_W'(i_delay_ticks);

    // Due test looks only at the chain head and its right neighbor (next head after a pop).
    assign w_head_due = w_valid[0] && !deadline_before(r_time, w_dl[0]);
    assign w_next_due = w_valid[1] && !deadline_before(r_time, w_dl[1]);
    assign w_budget   = (r_ndisp < NDISP_W'(MAX_OUT));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                     w_lcond;
            logic                     w_lvalid;
            logic [DEADLINE_W-1:0]    w_ldl;
            logic [PAYLOAD_WIDTH-1:0] w_lpay;
            if (g == 0) begin : g_head
                assign w_lcond  = 1'b0;
                assign w_lvalid = 1'b0;
                assign w_ldl    = '0;
                assign w_lpay   = '0;
            end else begin : g_body
                assign w_lcond  = w_cond[g-1];
                assign w_lvalid = w_valid[g-1];
                assign w_ldl    = w_dl[g-1];
                assign w_lpay   = w_pay[g-1];
            end
            dorq_cell #(
                .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_new_dl     (w_new_dl),
                .i_new_pay    (PAYLOAD_WIDTH'(i_payload)),
                .i_left_cond  (w_lcond),
                .i_left_valid (w_lvalid),
                .i_left_dl    (w_ldl),
                .i_left_pay   (w_lpay),
                .i_right_valid(w_valid[g+1]),
                .i_right_dl   (w_dl[g+1]),
                .i_right_pay  (w_pay[g+1]),
                .o_cond       (w_cond[g]),
                .o_valid      (w_valid[g]),
                .o_dl         (w_dl[g]),
                .o_pay        (w_pay[g])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_time    = r_time;
        n_rej     = r_rej;
        n_stopped = r_stopped;
        n_count   = r_count;
        n_ndisp   = r_ndisp;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_okind   = r_okind;
        n_opay    = r_opay;
        n_olast   = r_olast;
        w_cmd     = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_SCHEDULE: begin
                            n_ovalid = 1'b1;
                            n_opay   = '0;
                            n_olast  = 1'b1;
                            if (r_stopped || (r_count >= CNT_W'(CAPACITY))) begin
                                n_okind = KIND_REJECTED;
                                if (r_rej != '1) begin
                                    n_rej = r_rej + 32'd1;
                                end
                            end else begin
                                n_okind      = KIND_ACCEPTED;
                                w_cmd.insert = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                            end
                        end
                        OP_TICK: begin
                            n_time  = r_time + DEADLINE_W'(1);
                            n_ndisp = '0;
                            n_state = S_TICK;
                        end
                        OP_SHUTDOWN: begin
                            w_cmd.clear = 1'b1;
                            n_stopped   = 1'b1;
                            n_count     = '0;
                            n_ovalid    = 1'b1;
                            n_okind     = KIND_SHUTDOWN;
                            n_opay      = '0;
                            n_olast     = 1'b1;
                        end
                        default: begin
                            // unused op: no result, no state change
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    if (w_head_due && w_budget) begin
                        // pop the head; last when the new head is not due or budget runs out
                        w_cmd.pop = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                        n_ndisp   = r_ndisp + NDISP_W'(1);
                        n_okind   = KIND_DISPATCHED;
                        n_opay    = 32'(w_pay[0]);
                        n_olast   = !w_next_due ||
                                    ((r_ndisp + NDISP_W'(1)) == NDISP_W'(MAX_OUT));
                        if (n_olast) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        // only reached on the first step of a tick
                        n_okind = KIND_NOTHING;
                        n_opay  = '0;
                        n_olast = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_time    <= '0;
            r_rej     <= '0;
            r_stopped <= 1'b0;
            r_count   <= '0;
            r_ndisp   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_time    <= n_time;
            r_rej     <= n_rej;
            r_stopped <= n_stopped;
            r_count   <= n_count;
            r_ndisp   <= n_ndisp;
            r_ovalid  <= n_ovalid;
        end
    end

    // Result payload registers; pending and reject counts are read from live state,
    // which only moves when a new result is loaded.
    logic [4:0]  r_opend;
    logic [31:0] r_orej;

    always_ff @(posedge i_clk) begin
        r_okind <= n_okind;
        r_opay  <= n_opay;
        r_olast <= n_olast;
        r_opend <= 5'(n_count);
        r_orej  <= n_rej;
    end

    assign o_out_valid          = r_ovalid;
    assign o_kind               = r_okind;
    assign o_dispatched_payload = r_opay;
    assign o_pending_count      = r_opend;
    assign o_reject_count       = r_orej;
    assign o_last               = r_olast;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dorq_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 7;
    localparam int          QUEUE_DEPTH  = 16;
    localparam int          RANDOM_ITEMS = 400;
    // longest gap with no transfer on either side: receiver hold-off,
    // a full tick dispatch and the sender's longest gap, with margin
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          HOLD_CYCLES  = 80;
    // room for a tick that dispatches every held entry
    localparam int          DRAIN_CYCLES = 40;
    // op code with no meaning; the block drops it without a result
    localparam logic [1:0]  OP_RESERVED  = 2'd3;

    // one result as seen on the output port
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] payload;
        logic [4:0]  pending;
        logic [31:0] rejects;
        logic        last;
    } t_retry_result;

    // one row of directed stimulus; typed rows carry their result by hand
    typedef struct {
        logic [1:0]    op;
        logic [31:0]   payload;
        logic [15:0]   delay;
        bit            typed;
        t_retry_result want;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op          = OP_TICK;
    logic [31:0] i_payload     = '0;
    logic [15:0] i_delay_ticks = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [2:0]  o_kind;
    logic [31:0] o_dispatched_payload;
    logic [4:0]  o_pending_count;
    logic [31:0] o_reject_count;
    logic        o_last;

    // shadow copy of the queue, kept sorted exactly as the block keeps it
    logic [31:0]   held_deadline [QUEUE_DEPTH];
    logic [31:0]   held_payload  [QUEUE_DEPTH];
    int unsigned   held_total    = 0;
    logic [31:0]   clock_ticks   = '0;
    logic [31:0]   reject_tally  = '0;
    bit            is_shut       = 1'b0;

    t_retry_result fresh_results[$];   // results of the item just accepted
    t_retry_result awaited_results[$]; // results not yet seen on the port
    t_stim_row     directed_rows[$];

    int            mismatch_count   = 0;
    int            burst_left       = 0;
    bit            hold_off_request = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    deadline_ordered_retry_queue_top i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_op                 (i_op),
        .i_payload            (i_payload),
        .i_delay_ticks        (i_delay_ticks),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_kind               (o_kind),
        .o_dispatched_payload (o_dispatched_payload),
        .o_pending_count      (o_pending_count),
        .o_reject_count       (o_reject_count),
        .o_last               (o_last)
    );

    // ------------------------------------------------------------------
    // Queue predictor
    // ------------------------------------------------------------------

    function automatic t_retry_result mk_result(input logic [2:0] kind,
                                                input logic [31:0] pay,
                                                input logic [4:0] pend,
                                                input logic [31:0] rej,
                                                input logic last);
        t_retry_result r;
        r.kind    = kind;
        r.payload = pay;
        r.pending = pend;
        r.rejects = rej;
        r.last    = last;
        return r;
    endfunction

    // pending and reject fields reflect the state after the result
    function automatic void note_result(input logic [2:0] kind, input logic [31:0] pay,
                                        input logic last);
        fresh_results.push_back(mk_result(kind, pay, 5'(held_total), reject_tally, last));
    endfunction

    // a falls strictly ahead of b when the wrapped difference is negative
    function automatic bit is_earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    function automatic void forecast_queue_outcome(input logic [1:0] op,
                                                   input logic [31:0] pay,
                                                   input logic [15:0] dly);
        logic [31:0] due_at;
        logic [31:0] head_pay;
        int          pos;
        int          sent;
        fresh_results.delete();
        case (op)
            OP_SCHEDULE: begin
                due_at = clock_ticks + 32'(dly);
                if (is_shut || held_total >= QUEUE_DEPTH) begin
                    if (reject_tally != '1) reject_tally++;
                    note_result(KIND_REJECTED, '0, 1'b1);
                end else begin
                    // stable insert: skip every entry due at or before the new one
                    pos = 0;
                    while (pos < held_total && !is_earlier(due_at, held_deadline[pos])) pos++;
                    for (int i = held_total; i > pos; i--) begin
                        held_deadline[i] = held_deadline[i-1];
                        held_payload[i]  = held_payload[i-1];
                    end
                    held_deadline[pos] = due_at;
                    held_payload[pos]  = pay;
                    held_total++;
                    note_result(KIND_ACCEPTED, '0, 1'b1);
                end
            end
            OP_TICK: begin
                clock_ticks++;
                sent = 0;
                while (sent < MAX_OUT && held_total > 0 &&
                       !is_earlier(clock_ticks, held_deadline[0])) begin
                    head_pay = held_payload[0];
                    for (int i = 1; i < held_total; i++) begin
                        held_deadline[i-1] = held_deadline[i];
                        held_payload[i-1]  = held_payload[i];
                    end
                    held_total--;
                    note_result(KIND_DISPATCHED, head_pay, 1'b0);
                    sent++;
                end
                if (sent == 0) note_result(KIND_NOTHING, '0, 1'b1);
                else fresh_results[$].last = 1'b1;
            end
            OP_SHUTDOWN: begin
                is_shut    = 1'b1;
                held_total = 0;
                note_result(KIND_SHUTDOWN, '0, 1'b1);
            end
            default: ; // reserved code: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_stim_row plain_row(input logic [1:0] op, input logic [31:0] pay,
                                            input logic [15:0] dly);
        t_stim_row row;
        row.op      = op;
        row.payload = pay;
        row.delay   = dly;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_stim_row checked_row(input logic [1:0] op, input logic [31:0] pay,
                                              input logic [15:0] dly,
                                              input t_retry_result want);
        t_stim_row row;
        row       = plain_row(op, pay, dly);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    // mostly short delays so entries fall due; a few far out to fill slots
    function automatic logic [15:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)      return 16'($urandom_range(0, 6));
        else if (roll < 92) return 16'($urandom_range(0, 40));
        else if (roll < 98) return 16'($urandom_range(41, 150));
        else                return 16'($urandom());
    endfunction

    // burst/gap pacing of the sender; valid only drops when a gap starts
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drive one item, hold it until the transfer, then predict its results
    task automatic offer_item(input t_stim_row row);
        i_in_valid    <= 1'b1;
        i_op          <= row.op;
        i_payload     <= row.payload;
        i_delay_ticks <= row.delay;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        forecast_queue_outcome(row.op, row.payload, row.delay);
        if (row.typed) begin
            awaited_results.push_back(row.want);
        end else begin
            foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
        end
        pace_sender();
    endtask

    task automatic flag_mismatch(input string note);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, note);
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        int          closing_first;
        int          sent;
        int          roll;
        int          group;
        logic [15:0] lag;

        // Opening table. Typed rows: tick on an empty queue, zero-delay entry
        // with a zero payload and its dispatch, all-ones payload and delay,
        // and the reject once the queue is full.
        directed_rows.push_back(checked_row(OP_TICK, '0, '0,
                                mk_result(KIND_NOTHING, '0, 5'd0, '0, 1'b1)));
        directed_rows.push_back(checked_row(OP_SCHEDULE, '0, '0,
                                mk_result(KIND_ACCEPTED, '0, 5'd1, '0, 1'b1)));
        directed_rows.push_back(checked_row(OP_TICK, '1, '1,
                                mk_result(KIND_DISPATCHED, '0, 5'd0, '0, 1'b1)));
        directed_rows.push_back(checked_row(OP_SCHEDULE, '1, '1,
                                mk_result(KIND_ACCEPTED, '0, 5'd1, '0, 1'b1)));
        // equal deadlines: insertion order must be kept
        directed_rows.push_back(plain_row(OP_SCHEDULE, 32'hA5A5_A5A5, 16'd3));
        directed_rows.push_back(plain_row(OP_SCHEDULE, 32'h5A5A_5A5A, 16'd3));
        directed_rows.push_back(plain_row(OP_SCHEDULE, 32'h0000_0001, 16'd1));
        // fill to capacity with mixed deadlines
        for (int i = 0; i < 12; i++) begin
            directed_rows.push_back(plain_row(OP_SCHEDULE, 32'h1000_0000 + i * 32'h0101_0101,
                                              16'(i % 4 + 2)));
        end
        directed_rows.push_back(checked_row(OP_SCHEDULE, 32'h8000_0001, 16'd0,
                                mk_result(KIND_REJECTED, '0, 5'd16, 32'd1, 1'b1)));
        // ticks that dispatch one or several entries at once, and a dropped reserved code
        directed_rows.push_back(plain_row(OP_TICK, '0, '0));
        directed_rows.push_back(plain_row(OP_TICK, '0, '0));
        directed_rows.push_back(plain_row(OP_RESERVED, 32'hFFFF_0000, 16'h00FF));
        directed_rows.push_back(plain_row(OP_TICK, '0, '0));
        directed_rows.push_back(plain_row(OP_TICK, '0, '0));
        closing_first = directed_rows.size();
        // Closing rows: shutdown ends scheduling for good, so they run last:
        // shutdown, a schedule refused while stopped, a tick with nothing
        // left, a repeated shutdown and a dropped reserved code.
        directed_rows.push_back(plain_row(OP_SHUTDOWN, '0, '0));
        directed_rows.push_back(plain_row(OP_SCHEDULE, 32'h0F0F_0F0F, 16'd0));
        directed_rows.push_back(plain_row(OP_TICK, '0, '0));
        directed_rows.push_back(plain_row(OP_SHUTDOWN, '1, '1));
        directed_rows.push_back(plain_row(OP_RESERVED, '0, '0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < closing_first; r++) offer_item(directed_rows[r]);

        // Random part. It opens with a long back-to-back burst while the
        // receiver holds off, so the block backs up and drops its ready.
        hold_off_request = 1'b1;
        burst_left       = 40;
        sent             = 0;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                // group on one deadline, then ticks until it all falls due
                group = $urandom_range(3, 10);
                lag   = 16'($urandom_range(0, 3));
                repeat (group) offer_item(plain_row(OP_SCHEDULE, $urandom(), lag));
                repeat (lag + 1) offer_item(plain_row(OP_TICK, $urandom(), pick_delay()));
                sent += group + lag + 1;
            end else if (roll < 55) begin
                offer_item(plain_row(OP_SCHEDULE, $urandom(), pick_delay()));
                sent++;
            end else if (roll < 95) begin
                offer_item(plain_row(OP_TICK, $urandom(), 16'($urandom())));
                sent++;
            end else begin
                // dropped by the block; not counted
                offer_item(plain_row(OP_RESERVED, $urandom(), 16'($urandom())));
            end
        end

        for (int r = closing_first; r < directed_rows.size(); r++) offer_item(directed_rows[r]);

        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        // let a stray result show up, if any
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a random pattern that changes after a random span,
    // plus one long hold-off requested by the stimulus.
    // ------------------------------------------------------------------

    initial begin : receiver
        int hold_left;
        int stall_style;
        int span;
        int phase;
        hold_left   = 0;
        stall_style = 0;
        span        = 0;
        phase       = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    stall_style = $urandom_range(0, 3);
                    span        = $urandom_range(16, 80);
                end
                span--;
                case (stall_style)
                    0:       i_out_ready <= 1'b1;                          // no stalls
                    1:       i_out_ready <= 1'($urandom_range(0, 1));      // coin flip
                    2:       i_out_ready <= (phase % 4 != 0);              // every fourth
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every transfer is compared with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : result_check
        t_retry_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d payload %08h",
                                        o_kind, o_dispatched_payload));
            end else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                if (o_kind !== want.kind)
                    flag_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
                if (o_dispatched_payload !== want.payload)
                    flag_mismatch($sformatf("payload %08h, want %08h",
                                            o_dispatched_payload, want.payload));
                if (o_pending_count !== want.pending)
                    flag_mismatch($sformatf("pending %0d, want %0d",
                                            o_pending_count, want.pending));
                if (o_reject_count !== want.rejects)
                    flag_mismatch($sformatf("reject count %0d, want %0d",
                                            o_reject_count, want.rejects));
                if (o_last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run after too many cycles without any transfer
    // ------------------------------------------------------------------

    initial begin : stall_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                 $realtime, IDLE_LIMIT, awaited_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- deadline_ordered_retry_queue_top.f -----
rtl/dorq_pkg.sv
rtl/dorq_cell.sv
rtl/deadline_ordered_retry_queue_top.sv
dv/tb_top.sv
